// File: sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants, sector codes and the rounding divide shared by the
// HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Component width; FULL stands for 1.0 exactly.
  localparam int unsigned CB       = 16;
  localparam int unsigned FULL     = (1 << CB) - 1;
  localparam int unsigned HALF     = FULL >> 1;
  // Saturation below 5.0e-6 of full scale is grey: S * 200000 < FULL.
  localparam int unsigned GREY_MAX = (FULL - 1) / 200000;
  // Three components packed, padded to whole bytes.
  localparam int unsigned DATA_W   = ((3 * CB + 7) / 8) * 8;
  localparam int unsigned SEC_W    = 3;

  typedef logic [CB-1:0]    comp_t;
  typedef logic [2*CB-1:0]  prod_t;
  typedef logic [SEC_W-1:0] sec_t;

  // Sectors of the hue circle.
  localparam sec_t SEC_R_TO_Y = 3'd0;
  localparam sec_t SEC_Y_TO_G = 3'd1;
  localparam sec_t SEC_G_TO_C = 3'd2;
  localparam sec_t SEC_C_TO_B = 3'd3;
  localparam sec_t SEC_B_TO_M = 3'd4;
  localparam sec_t SEC_M_TO_R = 3'd5;
  localparam sec_t SEC_WRAP   = 3'd6;

  // Rounded divide by FULL = 2^CB - 1, half up. With y = hi * 2^CB + lo,
  // y = hi * FULL + (hi + lo), and hi + lo stays at or below 2 * FULL.
  function automatic comp_t rdiv(input prod_t x);
    prod_t       y;
    logic [CB:0] t;
    logic [CB:0] q;
    y = x + prod_t'(HALF);
    t = {1'b0, y[2*CB-1:CB]} + {1'b0, y[CB-1:0]};
    q = {1'b0, y[2*CB-1:CB]};
    if (t >= (CB+1)'(2 * FULL)) begin
      q = q + (CB+1)'(2);
    end else if (t >= (CB+1)'(FULL)) begin
      q = q + (CB+1)'(1);
    end
    return q[CB-1:0];
  endfunction

endpackage

// File: sv/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; five register stages, each with its own valid.
// A stage takes a new item when it is empty or its item moves on, so a stalled
// output holds only the stages behind it that are full.
// Reset (rst_n low, synchronous) empties every stage; payload registers keep data.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts a stream of HSV pixels to RGB, fixed-point fractions of full scale.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // hue_in, sat_in, val_in from the lowest bit up
  input  logic [hsv2rgb_pkg::DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // red_out, green_out, blue_out from the lowest bit up
  output logic [hsv2rgb_pkg::DATA_W-1:0]    out_tdata
);

  localparam int unsigned CB = hsv2rgb_pkg::CB;

  // Stage enables: a stage loads when it is empty or drains this cycle.
  logic en1, en2, en3, en4, en5;

  // Stage 1: sector split and grey test.
  logic                    vld1_r;
  hsv2rgb_pkg::sec_t       sec1_r;
  hsv2rgb_pkg::comp_t      rem1_r, sat1_r, val1_r;
  logic                    grey1_r;
  // Stage 2: first products.
  logic                    vld2_r;
  hsv2rgb_pkg::sec_t       sec2_r;
  hsv2rgb_pkg::comp_t      val2_r;
  logic                    grey2_r;
  hsv2rgb_pkg::prod_t      m_sr2_r, m_sf2_r, m_vs2_r;
  // Stage 3: rounded quotients.
  logic                    vld3_r;
  hsv2rgb_pkg::sec_t       sec3_r;
  hsv2rgb_pkg::comp_t      val3_r;
  logic                    grey3_r;
  hsv2rgb_pkg::comp_t      p1_3_r, nq2_3_r, nq3_3_r;
  // Stage 4: second products.
  logic                    vld4_r;
  hsv2rgb_pkg::sec_t       sec4_r;
  hsv2rgb_pkg::comp_t      val4_r;
  logic                    grey4_r;
  hsv2rgb_pkg::comp_t      p1_4_r;
  hsv2rgb_pkg::prod_t      m_p2_4_r, m_p3_4_r;
  // Stage 5: output register.
  logic                    vld5_r;
  logic                    grey5_r;
  hsv2rgb_pkg::comp_t      red5_r, grn5_r, blu5_r;

  assign en5       = !vld5_r || out_tready;
  assign en4       = !vld4_r || en5;
  assign en3       = !vld3_r || en4;
  assign en2       = !vld2_r || en3;
  assign en1       = !vld1_r || en2;
  assign in_tready = en1;

  // Stage 0 logic: h * 6 = a * 2^CB + b = a * FULL + (a + b).
  hsv2rgb_pkg::comp_t      hue_in, sat_in, val_in;
  logic [CB+2:0]           h6;
  logic [CB:0]             h6_sum;
  logic                    h6_wrap;
  hsv2rgb_pkg::comp_t      rem_nxt;
  hsv2rgb_pkg::sec_t       sec_raw, sec_nxt;
  logic                    grey_nxt;

  always_comb begin
    hue_in   = in_tdata[CB-1:0];
    sat_in   = in_tdata[2*CB-1:CB];
    val_in   = in_tdata[3*CB-1:2*CB];
    h6       = {3'b000, hue_in} * (CB+3)'(6);
    h6_sum   = {{(CB-2){1'b0}}, h6[CB+2:CB]} + {1'b0, h6[CB-1:0]};
    h6_wrap  = (h6_sum >= (CB+1)'(hsv2rgb_pkg::FULL));
    rem_nxt  = h6_wrap ? CB'(h6_sum - (CB+1)'(hsv2rgb_pkg::FULL)) : h6_sum[CB-1:0];
    sec_raw  = h6[CB+2:CB] + hsv2rgb_pkg::SEC_W'(h6_wrap);
    // Full hue lands on the seventh sector and is the same colour as hue 0.
    sec_nxt  = (sec_raw == hsv2rgb_pkg::SEC_WRAP) ? hsv2rgb_pkg::SEC_R_TO_Y : sec_raw;
    grey_nxt = (sat_in <= CB'(hsv2rgb_pkg::GREY_MAX));
  end

  // Stage 4 logic: final quotients and routing by sector.
  hsv2rgb_pkg::comp_t p2_c, p3_c;
  hsv2rgb_pkg::comp_t red_nxt, grn_nxt, blu_nxt;

  always_comb begin
    p2_c = hsv2rgb_pkg::rdiv(m_p2_4_r);
    p3_c = hsv2rgb_pkg::rdiv(m_p3_4_r);
    case (sec4_r)
      hsv2rgb_pkg::SEC_Y_TO_G: begin
        red_nxt = p2_c;   grn_nxt = val4_r; blu_nxt = p1_4_r;
      end
      hsv2rgb_pkg::SEC_G_TO_C: begin
        red_nxt = p1_4_r; grn_nxt = val4_r; blu_nxt = p3_c;
      end
      hsv2rgb_pkg::SEC_C_TO_B: begin
        red_nxt = p1_4_r; grn_nxt = p2_c;   blu_nxt = val4_r;
      end
      hsv2rgb_pkg::SEC_B_TO_M: begin
        red_nxt = p3_c;   grn_nxt = p1_4_r; blu_nxt = val4_r;
      end
      hsv2rgb_pkg::SEC_M_TO_R: begin
        red_nxt = val4_r; grn_nxt = p1_4_r; blu_nxt = p2_c;
      end
      default: begin
        red_nxt = val4_r; grn_nxt = p3_c;   blu_nxt = p1_4_r;
      end
    endcase
    if (grey4_r) begin
      red_nxt = val4_r;
      grn_nxt = val4_r;
      blu_nxt = val4_r;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_tvalid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en1) begin
      sec1_r  <= sec_nxt;
      rem1_r  <= rem_nxt;
      sat1_r  <= sat_in;
      val1_r  <= val_in;
      grey1_r <= grey_nxt;
    end
    if (en2) begin
      sec2_r  <= sec1_r;
      val2_r  <= val1_r;
      grey2_r <= grey1_r;
      // FULL - x is the bitwise complement for a CB-bit x.
      m_sr2_r <= {{CB{1'b0}}, sat1_r} * {{CB{1'b0}}, rem1_r};
      m_sf2_r <= {{CB{1'b0}}, sat1_r} * {{CB{1'b0}}, ~rem1_r};
      m_vs2_r <= {{CB{1'b0}}, val1_r} * {{CB{1'b0}}, ~sat1_r};
    end
    if (en3) begin
      sec3_r  <= sec2_r;
      val3_r  <= val2_r;
      grey3_r <= grey2_r;
      p1_3_r  <= hsv2rgb_pkg::rdiv(m_vs2_r);
      nq2_3_r <= ~hsv2rgb_pkg::rdiv(m_sr2_r);
      nq3_3_r <= ~hsv2rgb_pkg::rdiv(m_sf2_r);
    end
    if (en4) begin
      sec4_r   <= sec3_r;
      val4_r   <= val3_r;
      grey4_r  <= grey3_r;
      p1_4_r   <= p1_3_r;
      m_p2_4_r <= {{CB{1'b0}}, val3_r} * {{CB{1'b0}}, nq2_3_r};
      m_p3_4_r <= {{CB{1'b0}}, val3_r} * {{CB{1'b0}}, nq3_3_r};
    end
    if (en5) begin
      grey5_r <= grey4_r;
      red5_r  <= red_nxt;
      grn5_r  <= grn_nxt;
      blu5_r  <= blu_nxt;
    end
  end

  assign out_tvalid = vld5_r;
  assign out_tdata  = hsv2rgb_pkg::DATA_W'({blu5_r, grn5_r, red5_r});

  // The wrap of full hue must leave only the six real sectors downstream.
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r |-> (sec1_r <= hsv2rgb_pkg::SEC_M_TO_R))
    else $error("sector out of range after wrap");

  // A grey pixel leaves with three equal channels.
  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && grey5_r) |-> (red5_r == grn5_r && grn5_r == blu5_r))
    else $error("grey pixel with unequal channels");

  // A full output stage that is stalled must hold the stage behind it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && !out_tready && vld4_r) |=> (vld4_r && $stable(m_p2_4_r)))
    else $error("stage 4 item lost under stall");

  // Reset empties the pipeline; the first and last stages are checked.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!vld5_r && !vld1_r))
    else $error("pipeline not empty after reset");

endmodule
